// ----- rtl/u8vc_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 stream validator.
package u8vc_pkg;

  localparam int MAX_UNITS = 4;
  localparam int COUNT_W = 32;
  localparam int PEND_W = 2;
  localparam int LEAD_W = $clog2(MAX_UNITS + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef struct packed {
    logic [PEND_W-1:0]  pend;
    logic               err;
    logic [COUNT_W-1:0] points;
  } u8vc_state_t;

  typedef struct packed {
    logic               string_valid;
    logic [COUNT_W-1:0] code_point_count;
  } u8vc_result_t;

  // Run of leading ones from the top bit, capped at MAX_UNITS.
  function automatic logic [LEAD_W-1:0] lead_ones(input logic [7:0] b);
    logic [LEAD_W-1:0] n;
    logic              run;
    n = '0;
    run = 1'b1;
    for (int i = 0; i < MAX_UNITS; i++) begin
      if (run && b[7-i]) begin
        n = n + LEAD_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

// ----- rtl/u8vc_step.sv -----
// Per-byte state update and end-of-string result for the UTF-8 validator.
module u8vc_step
  import u8vc_pkg::*;
(
  input  u8vc_state_t  state_i,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output u8vc_state_t  state_nxt,
  output u8vc_result_t result
);

  logic [LEAD_W-1:0] k;
  u8vc_state_t       upd;
  logic [COUNT_W-1:0] points_inc;

  assign k = lead_ones(data_byte);
  assign points_inc = (state_i.points == COUNT_MAX) ? state_i.points
                                                    : state_i.points + COUNT_W'(1);

  always_comb begin
    upd = state_i;
    if (state_i.pend != '0) begin
      if (data_byte[7:6] != CONT_TAG) begin
        upd.err = 1'b1;
      end
      upd.pend = state_i.pend - PEND_W'(1);
    end else if (k == '0) begin
      upd.points = points_inc;
    end else if (k == LEAD_W'(1)) begin
      upd.err = 1'b1;
    end else begin
      upd.pend = PEND_W'(k - LEAD_W'(1));
      upd.points = points_inc;
    end
    if (upd.pend != '0) begin
      result.string_valid = 1'b0;
    end else begin
      result.string_valid = !upd.err;
    end
    result.code_point_count = result.string_valid ? upd.points : '0;
    state_nxt = last_byte ? '0 : upd;
  end

endmodule

// ----- rtl/utf8_stream_validate_count.sv -----
// Top level of the streaming UTF-8 structure checker and code point counter.
//
// Input channel: one string byte per request on in_data_byte, with
// in_last_byte set on the final byte. Requests are taken by in_valid and
// in_ready. Result channel: one request per string, issued after its final
// byte, carrying out_string_valid and out_code_point_count (zero when the
// string is invalid, saturating at all ones).
// Throughput is one byte per cycle while the input channel does not stall.
// A byte is held in an input register, then the state update and result
// logic write the result register, from which the result is offered.
// Reset (rst_n low, synchronous) clears the string state and empties both
// registers. When the receiver stalls, bytes that give no result keep
// flowing; a final byte waits in the input register until the result
// register is free, and only then does the input channel stall.
module utf8_stream_validate_count
  import u8vc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_string_valid,
  output logic [COUNT_W-1:0] out_code_point_count
);

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  u8vc_state_t  state_r;
  u8vc_state_t  state_nxt;
  u8vc_result_t result;
  u8vc_result_t res_r;
  logic         out_valid_r;
  logic         out_free;
  logic         s1_adv;

  u8vc_step u_step (
    .state_i   (state_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      res_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_string_valid = res_r.string_valid;
  assign out_code_point_count = res_r.code_point_count;

endmodule
